// ===== hw/rtl/bawa_pkg.sv =====
// Package with the constants, codes and types of the bounded array block.
`default_nettype none

package bawa_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned AVG_W     = 40;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_ITER  = AVG_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER + 1);

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [WORD_W-1:0] WORD_ONES  = '1;
  localparam logic [AVG_W-1:0]  AVG_EMPTY  = {{(AVG_W - FRAC_W){1'b1}}, {FRAC_W{1'b0}}};
  localparam logic              REG_ACTIVE_CAPACITY = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_GET    = 3'd1,
    REQ_SET    = 3'd2,
    REQ_MAX    = 3'd3,
    REQ_MIN    = 3'd4,
    REQ_SUM    = 3'd5,
    REQ_AVG    = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADIDX = 2'd2,
    STAT_EMPTY  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET,
    S_SCAN,
    S_DIV,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [AVG_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [AVG_W-1:0]  quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bawa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bawa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire [Width-1:0]                            wdata_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bawa_div.sv =====
// Radix-4 restoring divider for the scaled average, truncating toward zero.
`default_nettype none

module bawa_div
  import bawa_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] iter_q;
  logic [AVG_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dvs_q;
  logic                 neg_q;
  logic [CNT_W:0]       trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, quo_d[AVG_W-1]};
      quo_d = {quo_d[AVG_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + DIV_CNT_W'(1);
        if (iter_q == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (~quo_q + AVG_W'(1)) : quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_array_with_aggregates.sv =====
// Top level of the bounded word store with max, min, sum and average requests.
//
// Channel   Direction  Handshake               Word
// s_axis    in         tvalid/tready           tdata: index, value; tuser: req_type
// m_axis    out        tvalid/tready           tdata: data, average, fill_count; tuser: status
// apb       in         psel/penable/pready     active_capacity at address 0
//
// One request is taken at a time. Get reads the element memory only at a valid index.
// Max, min and sum read the stored words one after another through the single read port
// of the element memory; average on a non-empty store then runs the radix-4 divider.
// Reset empties the store and sets the capacity to 16.
// A result waiting in the output register does not block the next request; a second
// result waits until the first one has been taken.
`default_nettype none

module bounded_array_with_aggregates
  import bawa_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // tdata: index [7:0], value [39:8]
  input  wire [IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: req_type [2:0]
  input  wire [REQ_W-1:0]        s_axis_tuser_i,
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: data [31:0], average [71:32], fill_count [76:72], zero [79:77]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tuser: status [1:0]
  output logic [STAT_W-1:0]      m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  input  wire                    psel_i,
  input  wire                    penable_i,
  input  wire                    pwrite_i,
  input  wire [PADDR_W-1:0]      paddr_i,
  input  wire [PDATA_W-1:0]      pwdata_i,
  output logic [PDATA_W-1:0]     prdata_o,
  output logic                   pready_o
);

  fsm_e              state_q, state_d;
  req_e              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] val_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  ptr_q;
  logic              rd_vld_q;
  logic              have_q;
  logic [WORD_W-1:0] sum_q;
  logic [WORD_W-1:0] best_q;
  logic [WORD_W-1:0] res_data_q;
  logic [AVG_W-1:0]  res_avg_q;
  stat_e             res_stat_q;
  logic              out_vld_q;
  logic [WORD_W-1:0] out_data_q;
  logic [AVG_W-1:0]  out_avg_q;
  stat_e             out_stat_q;
  logic [FILL_W-1:0] out_fill_q;

  logic              in_acc;
  logic              full;
  logic              bad_idx;
  logic              scan_issue;
  logic              scan_done;
  logic              out_load;
  logic              better;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [AVG_W-1:0]  scaled;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign full    = (32'(cnt_q) >= 32'(cap_q)) || (32'(cnt_q) >= 32'(DEPTH));
  assign bad_idx = 32'(idx_q) >= 32'(cnt_q);
  assign better  = (req_q == REQ_MAX) ? ($signed(ram_rdata) > $signed(best_q))
                                      : ($signed(ram_rdata) < $signed(best_q));
  assign scaled  = {sum_q, {FRAC_W{1'b0}}};

  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ADDR_W'(idx_q);
    ram_raddr       = ADDR_W'(idx_q);
    scan_issue      = 1'b0;
    scan_done       = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      S_EXEC: begin
        if (req_q == REQ_APPEND) begin
          ram_we    = !full;
          ram_waddr = ADDR_W'(cnt_q);
        end else if (req_q == REQ_SET) begin
          ram_we = !bad_idx;
        end
      end
      S_SCAN: begin
        ram_raddr  = ADDR_W'(ptr_q);
        scan_issue = ptr_q < cnt_q;
        scan_done  = (ptr_q >= cnt_q) && !rd_vld_q;
      end
      S_OUT: begin
        out_load = !out_vld_q || m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_q)
          REQ_GET: state_d = bad_idx ? S_OUT : S_GET;
          REQ_MAX, REQ_MIN, REQ_SUM, REQ_AVG: state_d = S_SCAN;
          default: state_d = S_OUT;
        endcase
      end
      S_GET: state_d = S_OUT;
      S_SCAN: begin
        if (scan_done) begin
          state_d = (req_q == REQ_AVG && cnt_q != '0) ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cap_q     <= CAP_RESET;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      if (state_q == S_EXEC && req_q == REQ_APPEND && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_ACTIVE_CAPACITY) begin
        cap_q <= pwdata_i[CAP_W-1:0];
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_e'(s_axis_tuser_i);
      idx_q <= s_axis_tdata_i[IDX_W-1:0];
      val_q <= s_axis_tdata_i[IDX_W +: WORD_W];
    end
    case (state_q)
      S_EXEC: begin
        ptr_q     <= '0;
        sum_q     <= '0;
        have_q    <= 1'b0;
        res_avg_q <= '0;
        if (req_q == REQ_GET && bad_idx) begin
          res_data_q <= WORD_ONES;
        end else begin
          res_data_q <= '0;
        end
        case (req_q)
          REQ_APPEND: res_stat_q <= full ? STAT_FULL : STAT_OK;
          REQ_GET, REQ_SET: res_stat_q <= bad_idx ? STAT_BADIDX : STAT_OK;
          default: res_stat_q <= STAT_OK;
        endcase
      end
      S_GET: begin
        res_data_q <= ram_rdata;
      end
      S_SCAN: begin
        if (scan_issue) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          sum_q  <= sum_q + ram_rdata;
          have_q <= 1'b1;
          if (!have_q || better) begin
            best_q <= ram_rdata;
          end
        end
        if (scan_done) begin
          case (req_q)
            REQ_MAX, REQ_MIN: begin
              if (cnt_q == '0) begin
                res_data_q <= WORD_ONES;
                res_stat_q <= STAT_EMPTY;
              end else begin
                res_data_q <= best_q;
              end
            end
            REQ_AVG: begin
              if (cnt_q == '0) begin
                res_data_q <= WORD_ONES;
                res_avg_q  <= AVG_EMPTY;
                res_stat_q <= STAT_EMPTY;
              end else begin
                res_data_q <= sum_q;
              end
            end
            default: res_data_q <= sum_q;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_avg_q <= div_rsp.quot;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= res_data_q;
      out_avg_q  <= res_avg_q;
      out_stat_q <= res_stat_q;
      out_fill_q <= FILL_W'(cnt_q);
    end
  end

  assign div_req.start    = scan_done && req_q == REQ_AVG && cnt_q != '0;
  assign div_req.neg      = sum_q[WORD_W-1];
  assign div_req.dividend = sum_q[WORD_W-1] ? (~scaled + AVG_W'(1)) : scaled;
  assign div_req.divisor  = cnt_q;

  bawa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bawa_ram #(
    .Width (WORD_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - WORD_W - AVG_W - FILL_W){1'b0}},
                            out_fill_q, out_avg_q, out_data_q};
  assign m_axis_tuser_o  = out_stat_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i[2] == REG_ACTIVE_CAPACITY) ? PDATA_W'(cap_q) : '0;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(DEPTH))
    else $error("fill count beyond the built depth");

  a_append_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && req_q == REQ_APPEND && !full) |=>
      cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("successful append did not raise the fill count");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SCAN)
    else $error("scan read word returned outside the scan");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished while nobody waited for it");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench of the bounded word store with max, min, sum and average requests.
module testbench;
  import bawa_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_CAPACITY = PADDR_W'(0);
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN          = 3'd7;
  localparam int unsigned        SETTLE_CYCLES        = 64;
  localparam int unsigned        CYCLE_LIMIT          = 500000;
  localparam int unsigned        RANDOM_PHASES        = 30;
  localparam int unsigned        PHASE_ITEMS          = 25;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic [AVG_W-1:0]  average;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
  } result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic [REQ_W-1:0]      s_user    = '0;
  logic                  s_valid   = 1'b0;
  logic                  s_ready;
  logic [OUT_DATA_W-1:0] m_data;
  logic [STAT_W-1:0]     m_user;
  logic                  m_valid;
  logic                  m_ready   = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PADDR_W-1:0]    paddr     = '0;
  logic [PDATA_W-1:0]    pwdata    = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  logic [WORD_W-1:0] model_store [DEPTH];
  int unsigned       model_count = 0;
  logic [CAP_W-1:0]  model_cap   = CAP_RESET;

  result_t     pending_results [$];
  result_t     oldest_result;
  int unsigned mismatch_count = 0;
  bit          idle_enable    = 1'b1;

  bounded_array_with_aggregates u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL bounded_array_with_aggregates");
    $finish;
  end

  function automatic result_t predict_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                              logic [WORD_W-1:0] val);
    result_t                  r;
    logic signed [WORD_W-1:0] best;
    logic [WORD_W-1:0]        total;
    longint                   scaled;
    longint                   quotient;
    int unsigned              cap_in_use;
    r.data     = '0;
    r.average  = '0;
    r.status   = STAT_OK;
    cap_in_use = (model_cap < DEPTH) ? model_cap : DEPTH;
    total      = '0;
    for (int unsigned i = 0; i < model_count; i++) total += model_store[i];
    case (req)
      REQ_APPEND: begin
        if (model_count >= cap_in_use) begin
          r.status = STAT_FULL;
        end else begin
          model_store[model_count] = val;
          model_count++;
        end
      end
      REQ_GET: begin
        if (idx >= model_count) begin
          r.status = STAT_BADIDX;
          r.data   = WORD_ONES;
        end else begin
          r.data = model_store[idx];
        end
      end
      REQ_SET: begin
        if (idx >= model_count) r.status = STAT_BADIDX;
        else model_store[idx] = val;
      end
      REQ_MAX, REQ_MIN: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
          r.data   = WORD_ONES;
        end else begin
          best = model_store[0];
          for (int unsigned i = 1; i < model_count; i++) begin
            if (req == REQ_MAX ? ($signed(model_store[i]) > best)
                               : ($signed(model_store[i]) < best)) begin
              best = model_store[i];
            end
          end
          r.data = best;
        end
      end
      REQ_SUM: r.data = total;
      REQ_AVG: begin
        if (model_count == 0) begin
          r.status  = STAT_EMPTY;
          r.data    = WORD_ONES;
          r.average = AVG_EMPTY;
        end else begin
          scaled    = longint'($signed(total)) * 256;
          quotient  = scaled / longint'(model_count);
          r.data    = total;
          r.average = quotient[AVG_W-1:0];
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(model_count);
    return r;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, logic [AVG_W-1:0] want, logic [AVG_W-1:0] got);
    if (want !== got) note_failure($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("word %h with no request waiting", m_data));
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("data", AVG_W'(oldest_result.data), AVG_W'(m_data[31:0]));
        compare_field("average", oldest_result.average, m_data[71:32]);
        compare_field("status", AVG_W'(oldest_result.status), AVG_W'(m_user));
        compare_field("fill_count", AVG_W'(oldest_result.fill), AVG_W'(m_data[76:72]));
      end
    end
  end

  initial begin
    forever begin
      if (idle_enable && $urandom_range(0, 2) == 0) m_ready <= 1'b0;
      else m_ready <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                              logic [WORD_W-1:0] val);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_data  <= {val, idx};
    s_user  <= req;
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    pending_results.push_back(predict_request(req, idx, val));
  endtask

  task automatic wait_all_results();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(bit write, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_ACTIVE_CAPACITY;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    compare_field("active_capacity", AVG_W'(model_cap), AVG_W'(rdata[CAP_W-1:0]));
    @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b1, PDATA_W'(cap), rdata);
    model_cap = cap;
    @(posedge clk);
    check_capacity_readback();
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return WORD_W'($urandom_range(0, 20)) - WORD_W'(10);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    if (model_count > 0 && $urandom_range(0, 4) != 0) return IDX_W'($urandom_range(0, model_count));
    return IDX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [REQ_W-1:0] random_request();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick <= 5)  return REQ_APPEND;
    if (pick <= 8)  return REQ_GET;
    if (pick <= 10) return REQ_SET;
    if (pick <= 12) return REQ_MAX;
    if (pick <= 14) return REQ_MIN;
    if (pick <= 16) return REQ_SUM;
    if (pick <= 18) return REQ_AVG;
    return REQ_UNKNOWN;
  endfunction

  task automatic test_empty_store();
    check_capacity_readback();
    send_request(REQ_MAX, 8'd0, 32'd0);
    send_request(REQ_MIN, 8'd0, 32'd0);
    send_request(REQ_SUM, 8'd0, 32'd0);
    send_request(REQ_AVG, 8'd0, 32'd0);
    send_request(REQ_GET, 8'd0, 32'd0);
    send_request(REQ_SET, 8'd0, 32'h1234_5678);
    send_request(REQ_UNKNOWN, 8'hFF, 32'hFFFF_FFFF);
    wait_all_results();
  endtask

  task automatic test_extreme_words();
    send_request(REQ_APPEND, 8'd0, 32'h7FFF_FFFF);
    send_request(REQ_APPEND, 8'd0, 32'h8000_0000);
    send_request(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_request(REQ_APPEND, 8'd0, 32'h0000_0000);
    send_request(REQ_SUM, 8'd0, 32'd0);
    send_request(REQ_AVG, 8'd0, 32'd0);
    send_request(REQ_MAX, 8'd0, 32'd0);
    send_request(REQ_MIN, 8'd0, 32'd0);
    send_request(REQ_GET, 8'd3, 32'd0);
    send_request(REQ_GET, 8'd4, 32'd0);
    send_request(REQ_GET, 8'hFF, 32'd0);
    send_request(REQ_SET, 8'hFF, 32'h5555_5555);
    send_request(REQ_SET, 8'd1, 32'h7FFF_FFFF);
    send_request(REQ_SUM, 8'd0, 32'd0);
    send_request(REQ_AVG, 8'd0, 32'd0);
    wait_all_results();
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_request(REQ_APPEND, 8'd0, 32'hAAAA_AAAA);
    wait_all_results();
    set_capacity(5'd2);
    send_request(REQ_APPEND, 8'd0, 32'h0000_0001);
    send_request(REQ_SET, 8'd3, 32'hCAFE_0001);
    send_request(REQ_GET, 8'd3, 32'd0);
    wait_all_results();
    set_capacity(5'd5);
    send_request(REQ_APPEND, 8'd0, 32'h0000_0002);
    send_request(REQ_APPEND, 8'd0, 32'h0000_0003);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int unsigned cap;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_enable = (phase < RANDOM_PHASES - 4);
      if (phase < 10) begin
        cap = model_count + $urandom_range(0, 2);
        if (cap > 31) cap = 31;
      end else begin
        case ($urandom_range(0, 5))
          0:       cap = 0;
          1:       cap = 1;
          2:       cap = 16;
          3:       cap = 31;
          default: cap = $urandom_range(0, 31);
        endcase
      end
      set_capacity(CAP_W'(cap));
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), random_index(), random_word());
      end
      wait_all_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_extreme_words();
    test_capacity_limits();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("PASS bounded_array_with_aggregates");
    end else begin
      $display("FAIL bounded_array_with_aggregates");
    end
    $finish;
  end

endmodule
